@@ design/glzw_pkg.sv @@
// ---------------------------------------------------------------------------
// GIF LZW decoder package
// Shared constants and status codes for the decoder blocks.
// ---------------------------------------------------------------------------
package glzw_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int MAX_CODE_BITS = 12;
    localparam int MCS_MIN       = 2;
    localparam int MCS_MAX       = 8;
    localparam int MCS_RESET     = 8;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_BADCODE = 3'd2;
    localparam logic [2:0] ST_EARLY   = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;
    localparam logic [2:0] ST_BADMCS  = 3'd5;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_BYTE = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    localparam logic [0:0] REG_MCS      = 1'b0;
    localparam logic [0:0] REG_EXPECTED = 1'b1;

endpackage

@@ design/glzw_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, then read registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/gif_lzw_decoder_top.sv @@
// The table and stack reads are issued at the accept edge, the act cycle
// follows and the result word leaves at its end.
// No new word is taken during an act cycle: the string-table and pixel-stack
// memories feeding each walk or pop step have registered reads.
// A new word is taken only when the result slot is empty or drains that cycle.
// Reset (aresetn low, synchronous) clears control state, not the memories.
// ---------------------------------------------------------------------------
// GIF LZW decoder top level
// Bit unpacking, string table, prefix walk and pixel stack.
// ---------------------------------------------------------------------------
module gif_lzw_decoder_top #(
    parameter int TABLE_ENTRIES = glzw_pkg::TABLE_ENTRIES,
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pixel_valid,
    output logic [7:0]  m_pixel_index,
    output logic        m_last_pixel,
    output logic        m_need_byte,
    output logic [2:0]  m_status
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    // state registers
    logic [3:0]    mcs_reg;
    logic [31:0]   expected_reg;
    logic [AW:0]   sp_reg;
    logic [19:0]   bbuf_reg;
    logic [4:0]    bcnt_reg;
    logic [12:0]   nfc_reg;
    logic [3:0]    cw_reg;
    logic [12:0]   prev_reg;
    logic          prev_ok_reg;
    logic [7:0]    prev_first_reg; // first pixel of the previous code's string
    logic [12:0]   walk_reg;
    logic          walk_ok_reg;
    logic [31:0]   emitted_reg;
    logic          end_reg;
    logic [2:0]    status_reg;
    logic          busy_reg;     // act cycle pending
    logic [1:0]    mode_reg;
    logic [7:0]    byte_reg;

    // result slot
    logic          ov_reg;
    logic          o_pv_reg;
    logic [7:0]    o_pix_reg;
    logic          o_last_reg;
    logic          o_need_reg;
    logic [2:0]    o_st_reg;

    // memory ports
    logic [AW-1:0] raddr;
    logic [11:0]   pre_rd;
    logic [7:0]    suf_rd;
    logic [7:0]    fb_rd;
    logic [7:0]    stk_rd;
    logic          tbl_we;
    logic [AW-1:0] tbl_wa;
    logic [11:0]   pre_wd;
    logic [7:0]    suf_wd;
    logic [7:0]    fb_wd;
    logic          stk_we;
    logic [AW-1:0] stk_wa;
    logic [7:0]    stk_wd;
    logic [AW-1:0] stk_ra;

    // act-cycle combinational values
    logic [12:0]   clr;
    logic [12:0]   code;
    logic [12:0]   first;
    logic          cfg_fire;
    logic          s_fire;

    assign cfg_ready = !busy_reg;
    assign s_ready   = !busy_reg && !cfg_valid && (!ov_reg || m_ready);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_valid && s_ready;
    assign clr       = 13'd1 << mcs_reg;

    // read addresses issued at accept: walk entry, code entry or previous code entry, stack top
    always_comb begin
        code = 13'(bbuf_reg & ((20'd1 << cw_reg) - 20'd1));
        if (walk_ok_reg) begin
            raddr = walk_reg[AW-1:0];
        end else if (bcnt_reg >= 5'(cw_reg) && code >= clr && code < nfc_reg) begin
            raddr = code[AW-1:0];
        end else begin
            raddr = prev_reg[AW-1:0];
        end
        stk_ra = AW'(sp_reg - 1'b1);
    end

    glzw_ram #(.WIDTH(12), .DEPTH(TABLE_ENTRIES)) u_prefix (
        .aclk(aclk), .we(tbl_we), .waddr(tbl_wa), .wdata(pre_wd),
        .raddr(raddr), .rdata(pre_rd)
    );
    glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
        .aclk(aclk), .we(tbl_we), .waddr(tbl_wa), .wdata(suf_wd),
        .raddr(raddr), .rdata(suf_rd)
    );
    glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_first (
        .aclk(aclk), .we(tbl_we), .waddr(tbl_wa), .wdata(fb_wd),
        .raddr(raddr), .rdata(fb_rd)
    );
    glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .raddr(stk_ra), .rdata(stk_rd)
    );

    // act cycle: one bounded action per item
    logic [AW:0]  sp_next;
    logic [19:0]  bbuf_next;
    logic [4:0]   bcnt_next;
    logic [12:0]  nfc_next;
    logic [3:0]   cw_next;
    logic [12:0]  prev_next;
    logic         prev_ok_next;
    logic [7:0]   prev_first_next;
    logic [12:0]  walk_next;
    logic         walk_ok_next;
    logic [31:0]  emitted_next;
    logic         end_next;
    logic [2:0]   status_next;
    logic         pv_next;
    logic [7:0]   pix_next;
    logic         last_next;
    logic [12:0]  first_prev;
    logic         grow;

    always_comb begin
        sp_next      = sp_reg;
        bbuf_next    = bbuf_reg;
        bcnt_next    = bcnt_reg;
        nfc_next     = nfc_reg;
        cw_next      = cw_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        prev_first_next = prev_first_reg;
        walk_next    = walk_reg;
        walk_ok_next = walk_ok_reg;
        emitted_next = emitted_reg;
        end_next     = end_reg;
        status_next  = status_reg;
        pv_next      = 1'b0;
        pix_next     = 8'd0;
        last_next    = 1'b0;
        tbl_we       = 1'b0;
        tbl_wa       = nfc_reg[AW-1:0];
        pre_wd       = 12'(prev_reg);
        stk_we       = 1'b0;
        stk_wa       = sp_reg[AW-1:0];
        stk_wd       = 8'd0;
        first        = 13'd0;
        first_prev   = 13'(prev_first_reg);
        grow         = 1'b0;
        if (busy_reg && status_reg == glzw_pkg::ST_RUN) begin
            if (mcs_reg < 4'(glzw_pkg::MCS_MIN) || mcs_reg > 4'(glzw_pkg::MCS_MAX)) begin
                status_next = glzw_pkg::ST_BADMCS;
            end else if (emitted_reg >= expected_reg) begin
                status_next = glzw_pkg::ST_DONE;
            end else if (mode_reg == glzw_pkg::MODE_BYTE) begin
                if (end_reg || bcnt_reg >= 5'(cw_reg)) begin
                    status_next = glzw_pkg::ST_OVERRUN;
                end else begin
                    bbuf_next = bbuf_reg | (20'(byte_reg) << bcnt_reg);
                    bcnt_next = bcnt_reg + 5'd8;
                end
            end else if (mode_reg == glzw_pkg::MODE_END) begin
                end_next = 1'b1;
            end else if (mode_reg == glzw_pkg::MODE_TICK) begin
                if (walk_ok_reg) begin
                    // push one string byte, follow prefix
                    if (walk_reg < clr) begin
                        stk_wd = walk_reg[7:0];
                        walk_ok_next = 1'b0;
                    end else begin
                        stk_wd = suf_rd;
                        walk_next = 13'(pre_rd);
                    end
                    if (sp_reg < (AW+1)'(TABLE_ENTRIES)) begin
                        stk_we = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                end else if (sp_reg != '0) begin
                    // pop one pixel
                    sp_next = sp_reg - 1'b1;
                    pix_next = stk_rd;
                    pv_next = 1'b1;
                    emitted_next = emitted_reg + 32'd1;
                    if (emitted_next == expected_reg) begin
                        last_next = 1'b1;
                        status_next = glzw_pkg::ST_DONE;
                        sp_next = '0;
                    end
                end else if (bcnt_reg >= 5'(cw_reg)) begin
                    bbuf_next = bbuf_reg >> cw_reg;
                    bcnt_next = bcnt_reg - 5'(cw_reg);
                    if (code == clr) begin
                        nfc_next = clr + 13'd2;
                        cw_next = mcs_reg + 4'd1;
                        prev_ok_next = 1'b0;
                    end else if (code == clr + 13'd1) begin
                        status_next = glzw_pkg::ST_EARLY;
                    end else if (code < clr || code < nfc_reg ||
                                 (code == nfc_reg && prev_ok_reg)) begin
                        if (code < clr) begin
                            first = code;
                        end else if (code < nfc_reg) begin
                            first = 13'(fb_rd);
                        end else begin
                            first = first_prev;
                            stk_wd = first[7:0];
                            if (sp_reg < (AW+1)'(TABLE_ENTRIES)) begin
                                stk_we = 1'b1;
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        walk_next = (code == nfc_reg) ? prev_reg : code;
                        walk_ok_next = 1'b1;
                        if (prev_ok_reg && nfc_reg < 13'(TABLE_ENTRIES)) begin
                            tbl_we = 1'b1;
                            nfc_next = nfc_reg + 13'd1;
                            grow = (nfc_next == (13'd1 << cw_reg)) &&
                                   (cw_reg < 4'(MAX_CODE_BITS));
                            if (grow) begin
                                cw_next = cw_reg + 4'd1;
                            end
                        end
                        prev_next = code;
                        prev_ok_next = 1'b1;
                        prev_first_next = first[7:0];
                    end else begin
                        status_next = glzw_pkg::ST_BADCODE;
                    end
                end else if (end_reg) begin
                    status_next = glzw_pkg::ST_EARLY;
                end
            end
        end
        suf_wd = first[7:0];
        fb_wd  = first_prev[7:0];
    end

    // hold state, advance on act cycle, apply configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcs_reg      <= 4'(glzw_pkg::MCS_RESET);
            expected_reg <= 32'd1;
            sp_reg       <= '0;
            bbuf_reg     <= '0;
            bcnt_reg     <= '0;
            nfc_reg      <= (13'd1 << glzw_pkg::MCS_RESET) + 13'd2;
            cw_reg       <= 4'(glzw_pkg::MCS_RESET + 1);
            prev_reg     <= '0;
            prev_ok_reg  <= 1'b0;
            prev_first_reg <= '0;
            walk_reg     <= '0;
            walk_ok_reg  <= 1'b0;
            emitted_reg  <= '0;
            end_reg      <= 1'b0;
            status_reg   <= glzw_pkg::ST_RUN;
            busy_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end else begin
            if (m_ready) begin
                ov_reg <= 1'b0;
            end
            if (cfg_fire) begin
                if (cfg_index == glzw_pkg::REG_MCS) begin
                    mcs_reg     <= cfg_data[3:0];
                    nfc_reg     <= (13'd1 << cfg_data[3:0]) + 13'd2;
                    cw_reg      <= cfg_data[3:0] + 4'd1;
                    prev_ok_reg <= 1'b0;
                    walk_ok_reg <= 1'b0;
                    sp_reg      <= '0;
                end else begin
                    expected_reg <= cfg_data;
                end
            end
            if (s_fire) begin
                busy_reg <= 1'b1;
                mode_reg <= s_mode;
                byte_reg <= s_data_byte;
            end
            if (busy_reg) begin
                busy_reg    <= 1'b0;
                sp_reg      <= sp_next;
                bbuf_reg    <= bbuf_next;
                bcnt_reg    <= bcnt_next;
                nfc_reg     <= nfc_next;
                cw_reg      <= cw_next;
                prev_reg    <= prev_next;
                prev_ok_reg <= prev_ok_next;
                prev_first_reg <= prev_first_next;
                walk_reg    <= walk_next;
                walk_ok_reg <= walk_ok_next;
                emitted_reg <= emitted_next;
                end_reg     <= end_next;
                status_reg  <= status_next;
                ov_reg      <= 1'b1;
                o_pv_reg    <= pv_next;
                o_pix_reg   <= pix_next;
                o_last_reg  <= last_next;
                o_need_reg  <= (status_next == glzw_pkg::ST_RUN) && !end_next &&
                               (bcnt_next < 5'(cw_next));
                o_st_reg    <= status_next;
            end
        end
    end

    assign m_valid       = ov_reg;
    assign m_pixel_valid = o_pv_reg;
    assign m_pixel_index = o_pix_reg;
    assign m_last_pixel  = o_last_reg;
    assign m_need_byte   = o_need_reg;
    assign m_status      = o_st_reg;

    // a taken word is followed by its act cycle, no word enters during it, and a last pixel comes with done status
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> busy_reg) else $error("act cycle missing");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready) else $error("word taken during act cycle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_pixel) |-> (m_status == glzw_pkg::ST_DONE))
        else $error("last pixel without done");

endmodule

@@ dv/gif_lzw_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GIF LZW decoder checker
// Watches the config, input and result channels, predicts every result word
// from a shadow copy of the decoder state and compares it field by field.
// ---------------------------------------------------------------------------
module gif_lzw_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_pixel_valid,
    input  logic [7:0]  m_pixel_index,
    input  logic        m_last_pixel,
    input  logic        m_need_byte,
    input  logic [2:0]  m_status,
    output int          fail_count,
    output int          words_pending,
    output logic        pred_need_byte,
    output logic        pred_busy,
    output logic [2:0]  pred_status,
    output int          pred_bit_count
);

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] pixel_index;
        logic       last_pixel;
        logic       need_byte;
        logic [2:0] status;
    } pixel_word_t;

    pixel_word_t pixel_words_due[$];

    // shadow decoder state
    logic [11:0] sh_prefix [glzw_pkg::TABLE_ENTRIES];
    logic [7:0]  sh_suffix [glzw_pkg::TABLE_ENTRIES];
    logic [7:0]  sh_first  [glzw_pkg::TABLE_ENTRIES];
    logic [7:0]  sh_stack  [glzw_pkg::TABLE_ENTRIES];
    int          sh_mcs;
    int          sh_sp, sh_bits, sh_nbits, sh_next_free, sh_width;
    int          sh_prev, sh_walk;
    logic        sh_prev_ok, sh_walking, sh_end_seen;
    logic [31:0] sh_emitted, sh_expected_px;
    logic [2:0]  sh_status;

    task automatic restart_strings();
        sh_next_free = ((1 << (sh_mcs & 15)) + 2) & 13'h1FFF;
        sh_width     = ((sh_mcs & 15) + 1) & 15;
        sh_prev_ok   = 1'b0;
    endtask

    task automatic stack_push(input int v);
        if (sh_sp < glzw_pkg::TABLE_ENTRIES) begin
            sh_stack[sh_sp] = v[7:0];
            sh_sp++;
        end
    endtask

    function automatic int first_pixel(input int c, input int clear_code);
        if (c < clear_code) return c & 255;
        if (c < glzw_pkg::TABLE_ENTRIES) return int'(sh_first[c]);
        return 0;
    endfunction

    // take one code off the bit buffer and extend the string table
    task automatic take_code(input int clear_code);
        int code, fp;
        code = sh_bits & ((1 << sh_width) - 1);
        sh_bits  = sh_bits >> sh_width;
        sh_nbits = sh_nbits - sh_width;
        if (code == clear_code) begin
            restart_strings();
            return;
        end
        if (code == clear_code + 1) begin
            sh_status = glzw_pkg::ST_EARLY;
            return;
        end
        if (code < clear_code || (code > clear_code + 1 && code < sh_next_free)) begin
            fp = first_pixel(code, clear_code);
            sh_walk = code;
            sh_walking = 1'b1;
        end else if (code == sh_next_free && sh_prev_ok) begin
            // string equals previous string plus its own first pixel
            fp = first_pixel(sh_prev, clear_code);
            stack_push(fp);
            sh_walk = sh_prev;
            sh_walking = 1'b1;
        end else begin
            sh_status = glzw_pkg::ST_BADCODE;
            return;
        end
        if (sh_prev_ok && sh_next_free < glzw_pkg::TABLE_ENTRIES) begin
            sh_prefix[sh_next_free] = sh_prev[11:0];
            sh_suffix[sh_next_free] = fp[7:0];
            sh_first[sh_next_free]  = 8'(first_pixel(sh_prev, clear_code));
            sh_next_free++;
            if (sh_next_free == (1 << sh_width) && sh_width < glzw_pkg::MAX_CODE_BITS)
                sh_width++;
        end
        sh_prev = code;
        sh_prev_ok = 1'b1;
    endtask

    task automatic decode_word(input logic [1:0] mode, input logic [7:0] data_byte,
                               output pixel_word_t w);
        int clear_code;
        w = '0;
        if (sh_status == glzw_pkg::ST_RUN) begin
            clear_code = 1 << sh_mcs;
            if (sh_mcs < glzw_pkg::MCS_MIN || sh_mcs > glzw_pkg::MCS_MAX) begin
                sh_status = glzw_pkg::ST_BADMCS;
            end else if (sh_emitted >= sh_expected_px) begin
                sh_status = glzw_pkg::ST_DONE;
            end else if (mode == glzw_pkg::MODE_BYTE) begin
                if (sh_end_seen || sh_nbits >= sh_width) begin
                    sh_status = glzw_pkg::ST_OVERRUN;
                end else begin
                    sh_bits  = (sh_bits | (int'(data_byte) << sh_nbits)) & 20'hFFFFF;
                    sh_nbits = sh_nbits + 8;
                end
            end else if (mode == glzw_pkg::MODE_END) begin
                sh_end_seen = 1'b1;
            end else if (mode == glzw_pkg::MODE_TICK) begin
                if (sh_walking) begin
                    if (sh_walk < clear_code) begin
                        stack_push(sh_walk);
                        sh_walking = 1'b0;
                    end else if (sh_walk < glzw_pkg::TABLE_ENTRIES) begin
                        stack_push(int'(sh_suffix[sh_walk]));
                        sh_walk = int'(sh_prefix[sh_walk]);
                    end else begin
                        sh_walking = 1'b0;
                    end
                end else if (sh_sp > 0) begin
                    sh_sp--;
                    w.pixel_index = sh_stack[sh_sp];
                    w.pixel_valid = 1'b1;
                    sh_emitted++;
                    if (sh_emitted == sh_expected_px) begin
                        w.last_pixel = 1'b1;
                        sh_status = glzw_pkg::ST_DONE;
                        sh_sp = 0;
                    end
                end else if (sh_nbits >= sh_width) begin
                    take_code(clear_code);
                end else if (sh_end_seen) begin
                    sh_status = glzw_pkg::ST_EARLY;
                end
            end
        end
        w.need_byte = (sh_status == glzw_pkg::ST_RUN && !sh_end_seen && sh_nbits < sh_width);
        w.status = sh_status;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_word_t w, due;
        if (!aresetn) begin
            fail_count = 0;
            sh_mcs = glzw_pkg::MCS_RESET;
            sh_expected_px = 32'd1;
            sh_sp = 0; sh_bits = 0; sh_nbits = 0;
            sh_walk = 0; sh_walking = 1'b0; sh_prev = 0;
            sh_emitted = '0; sh_end_seen = 1'b0; sh_status = glzw_pkg::ST_RUN;
            restart_strings();
            pixel_words_due.delete();
        end else begin
            // compare a result word with the oldest prediction
            if (m_valid && m_ready) begin
                if (pixel_words_due.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h", $time,
                             {m_pixel_valid, m_pixel_index, m_last_pixel, m_need_byte,
                              m_status});
                    fail_count++;
                end else begin
                    due = pixel_words_due.pop_front();
                    check_field("pixel_valid", int'(due.pixel_valid), int'(m_pixel_valid));
                    check_field("pixel_index", int'(due.pixel_index), int'(m_pixel_index));
                    check_field("last_pixel", int'(due.last_pixel), int'(m_last_pixel));
                    check_field("need_byte", int'(due.need_byte), int'(m_need_byte));
                    check_field("status", int'(due.status), int'(m_status));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == glzw_pkg::REG_MCS) begin
                    sh_mcs = cfg_data & 15;
                    restart_strings();
                    sh_walking = 1'b0;
                    sh_sp = 0;
                end else begin
                    sh_expected_px = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                decode_word(s_mode, s_data_byte, w);
                pixel_words_due = {pixel_words_due, w};
            end
        end
        words_pending  <= pixel_words_due.size();
        pred_need_byte <= (sh_status == glzw_pkg::ST_RUN && !sh_end_seen && sh_nbits < sh_width);
        pred_busy      <= sh_walking || sh_sp > 0;
        pred_status    <= sh_status;
        pred_bit_count <= sh_nbits;
    end

    // anything still expected at the end is reported by the top via words_pending
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GIF LZW decoder testbench
// Encodes random well-formed LZW code streams at several code sizes, paces
// bytes and ticks from the predicted decoder state, varies idling on both
// channels and ends with a stream that completes the pixel count.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam logic [31:0] PIXELS_MAX = 32'hFFFE0001;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    logic        aclk, aresetn;
    logic        cfg_valid, cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid, s_ready;
    logic [1:0]  s_mode;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_pixel_valid, m_last_pixel, m_need_byte;
    logic [7:0]  m_pixel_index;
    logic [2:0]  m_status;

    int          fail_count, words_pending, pred_bit_count;
    logic        pred_need_byte, pred_busy;
    logic [2:0]  pred_status;

    int sender_idle_pct, receiver_stall_pct;
    int watchdog_count = 0;
    logic hold_go;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    // encoder side of the stream
    int           enc_mcs, enc_clear, enc_next_free, enc_width, enc_skip;
    logic         enc_prev_ok;
    logic [127:0] enc_acc;
    int           enc_acc_n;

    gif_lzw_decoder_top dut (.*);

    gif_lzw_checker checker_i (.*);

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            watchdog_count <= 0;
        else
            watchdog_count <= watchdog_count + 1;
        if (watchdog_count == WATCHDOG_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic enc_restart();
        enc_clear     = 1 << enc_mcs;
        enc_next_free = enc_clear + 2;
        enc_width     = enc_mcs + 1;
        enc_prev_ok   = 1'b0;
    endtask

    // track the decoder's table growth for one code
    task automatic enc_apply(input int code);
        if (code == enc_clear) begin
            enc_restart();
        end else begin
            if (enc_prev_ok && enc_next_free < glzw_pkg::TABLE_ENTRIES) begin
                enc_next_free++;
                if (enc_next_free == (1 << enc_width) &&
                    enc_width < glzw_pkg::MAX_CODE_BITS)
                    enc_width++;
            end
            enc_prev_ok = 1'b1;
        end
    endtask

    task automatic enc_pack(input int code);
        enc_acc = enc_acc | (128'(code >> enc_skip) << enc_acc_n);
        enc_acc_n = enc_acc_n + enc_width - enc_skip;
        enc_skip = 0;
        enc_apply(code);
    endtask

    // pick a random legal code: roots, known strings, the self-referencing
    // case and the occasional clear
    task automatic enc_random_code();
        int r, code;
        r = $urandom_range(99);
        code = $urandom_range(enc_clear - 1);
        if (enc_skip > 0)
            code = 0;
        else if (!enc_prev_ok)
            code = $urandom_range(enc_clear - 1);
        else if (r < 3)
            code = enc_clear;
        else if (r < 15 && enc_next_free < glzw_pkg::TABLE_ENTRIES)
            code = enc_next_free;
        else if (r < 50 && enc_next_free > enc_clear + 2)
            code = $urandom_range(enc_next_free - 1, enc_clear + 2);
        enc_pack(code);
    endtask

    // line up with zero padding bits left in the decoder's bit buffer
    task automatic enc_sync();
        int left;
        left = pred_bit_count;
        while (left >= enc_width) begin
            left = left - enc_width;
            enc_apply(0);
        end
        enc_skip = left;
        enc_acc = '0;
        enc_acc_n = 0;
    endtask

    task automatic send_word(input logic [1:0] mode, input logic [7:0] data_byte);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_data_byte <= data_byte;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one item: a byte when the decoder wants one, else a tick, now and then an
    // unused-mode word; padding with zeros when flushing the stream
    task automatic next_word(input logic flushing);
        logic want_byte;
        want_byte = pred_need_byte &&
                    (!pred_busy || $urandom_range(1) == 1) &&
                    (!flushing || enc_acc_n > 0);
        if ($urandom_range(49) == 0) begin
            send_word(MODE_UNUSED, 8'($urandom));
        end else if (want_byte) begin
            while (!flushing && enc_acc_n < 8)
                enc_random_code();
            send_word(glzw_pkg::MODE_BYTE, enc_acc[7:0]);
            enc_acc = enc_acc >> 8;
            enc_acc_n = (enc_acc_n > 8) ? enc_acc_n - 8 : 0;
        end else begin
            send_word(glzw_pkg::MODE_TICK, 8'($urandom));
        end
    endtask

    // flush the stream, then wait until every result word has come
    task automatic drain();
        while (!(pred_need_byte && !pred_busy && enc_acc_n == 0) &&
               pred_status == glzw_pkg::ST_RUN)
            next_word(1'b1);
        s_valid <= 1'b0;
        while (words_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input int code_size, input int words,
                             input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        write_reg(glzw_pkg::REG_MCS, 32'(code_size));
        enc_mcs = code_size;
        enc_restart();
        @(negedge aclk);
        enc_sync();
        repeat (words) next_word(1'b0);
        drain();
    endtask

    initial begin
        int guard;
        aresetn = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_mode = glzw_pkg::MODE_TICK; s_data_byte = '0;
        hold_go = 1'b0; sender_idle_pct = 0; receiver_stall_pct = 0;
        enc_acc = '0; enc_acc_n = 0; enc_skip = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: widest roots, extreme root values, self-reference, clear
        write_reg(glzw_pkg::REG_EXPECTED, PIXELS_MAX);
        write_reg(glzw_pkg::REG_MCS, 32'd8);
        enc_mcs = 8;
        enc_restart();
        enc_sync();
        enc_pack(0);
        enc_pack(255);
        enc_pack(enc_next_free);
        enc_pack(enc_clear);
        enc_pack(255);
        enc_pack(255);
        enc_pack(enc_next_free);
        enc_pack(enc_clear + 2);
        send_word(MODE_UNUSED, 8'hFF);
        send_word(glzw_pkg::MODE_TICK, 8'h00);
        drain();

        // random streams across code sizes and idling patterns
        run_phase(2, 200, 0, 0);
        run_phase(5, 180, 79, 0);
        hold_go = 1'b1;
        run_phase(8, 180, 0, 79);
        run_phase(3, 180, 14, 14);
        run_phase(7, 150, 0, 0);

        // finish the image a few pixels on
        write_reg(glzw_pkg::REG_EXPECTED, checker_i.sh_emitted + 32'd5);
        sender_idle_pct = 10;
        receiver_stall_pct = 10;
        guard = 0;
        while (pred_status == glzw_pkg::ST_RUN && guard < 2000) begin
            next_word(1'b0);
            guard++;
        end
        send_word(glzw_pkg::MODE_END, 8'h00);
        send_word(glzw_pkg::MODE_BYTE, 8'hA5);
        send_word(MODE_UNUSED, 8'h5A);
        s_valid <= 1'b0;

        while (words_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && words_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
